// ===== rtl/core/fqt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqt_pkg
// Types and codes shared by the timeout queue, its entry store and checker.
// ----------------------------------------------------------------------------
package fqt_pkg;

	// operation codes
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [15:0] WAIT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] customer_id;
		logic [15:0] wait_limit;
		logic [15:0] service_time;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] removed_id;
		logic [15:0] removed_service_time;
		logic [6:0]  expired_count;
		logic [6:0]  queue_length;
	} rsp_word_t;

	// one stored entry
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] limit;
		logic [15:0] svc;
		logic [15:0] waited;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEQ,
		S_TICK,
		S_FIN
	} state_t;

endpackage

// ===== rtl/core/fqt_entry_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqt_entry_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fqt_entry_ram #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
	output fqt_pkg::entry_t                rd_data,
	input  logic                           wr_en,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
	input  fqt_pkg::entry_t                wr_data
);
	import fqt_pkg::*;

	entry_t mem [QUEUE_DEPTH];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/fifo_queue_with_entry_timeout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_entry_timeout
// Bounded FIFO of entries, each with a wait limit; a tick ages and expires.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one word per operation: enqueue, dequeue or tick.
//   rsp channel returns exactly one word per request, in request order.
//   Entries live in a ring buffer in a single-port-read, single-port-write
//   RAM; head, tail and count are registers.
// Flow (accept to rsp_valid, receiver not stalling):
//   enqueue, unused code or dequeue on an empty queue: straight to S_FIN;
//   dequeue: through S_DEQ, which takes the head entry read at accept;
//   tick: through S_TICK, one entry read, tested and compacted per cycle
//   through the RAM read port, survivors written back behind the read pointer.
// Throughput: one request at a time; req_stall is high from accept until the
//   result is loaded into the rsp register, so the next request can be taken
//   while the previous result still waits for the receiver.
// Reset: the queue is empty, rsp_valid low; RAM contents are not cleared and
//   are never read before they are written.
// Receiver stall: rsp holds its word; a finished result waits in the core
//   and req stays stalled until the rsp register frees up.
// ----------------------------------------------------------------------------
module fifo_queue_with_entry_timeout #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  fqt_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output fqt_pkg::rsp_word_t rsp
);
	import fqt_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == LAST_PTR) ? '0 : p + 1'b1;
	endfunction

	state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [PW-1:0] head_q, tail_q;

	// tick walk
	logic [PW-1:0] rp_q, wp_q;
	logic [CW-1:0] issue_q, proc_q, kept_q, exp_q;
	logic          rd_vld_s1;

	rsp_word_t res_q, res_d, rsp_q;
	logic      rsp_valid_q;

	logic    accept, fin_go, tick_done, is_full, is_empty, keep;
	logic    rd_en, wr_en;
	logic [PW-1:0] rd_addr, wr_addr;
	entry_t  rd_data, wr_data;

	fqt_entry_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// handshake and status decode
	always_comb begin
		req_stall = (state_q != S_IDLE);
		accept    = req_valid && !req_stall;
		fin_go    = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);
		tick_done = (state_q == S_TICK) && (proc_q == count_q);
		is_full   = (count_q == FULL_CNT);
		is_empty  = (count_q == '0);
		keep      = (rd_data.waited < rd_data.limit);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.operation)
						OP_DEQ:  state_d = is_empty ? S_FIN : S_DEQ;
						OP_TICK: state_d = S_TICK;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_DEQ:  state_d = S_FIN;
			S_TICK: begin
				if (tick_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = tail_q;
		wr_data = '{id: req.customer_id, limit: req.wait_limit,
			svc: req.service_time, waited: '0};
		case (state_q)
			S_IDLE: begin
				if (accept && req.operation == OP_DEQ && !is_empty) begin
					rd_en = 1'b1;
				end
				if (accept && req.operation == OP_ENQ && !is_full) begin
					wr_en = 1'b1;
				end
			end
			S_TICK: begin
				rd_en   = (issue_q != count_q);
				rd_addr = rp_q;
				wr_en   = rd_vld_s1 && keep;
				wr_addr = wp_q;
				wr_data = rd_data;
				if (rd_data.waited != WAIT_MAX) begin
					wr_data.waited = rd_data.waited + 16'd1;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			rp_q        <= '0;
			wp_q        <= '0;
			issue_q     <= '0;
			proc_q      <= '0;
			kept_q      <= '0;
			exp_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == S_TICK) && rd_en;

			if (state_q == S_IDLE && accept) begin
				rp_q    <= head_q;
				wp_q    <= head_q;
				issue_q <= '0;
				proc_q  <= '0;
				kept_q  <= '0;
				exp_q   <= '0;
			end

			if (wr_en && state_q == S_IDLE) begin
				count_q <= count_q + 1'b1;
				tail_q  <= ptr_inc(tail_q);
			end

			if (state_q == S_DEQ) begin
				count_q <= count_q - 1'b1;
				head_q  <= ptr_inc(head_q);
			end

			// tick walk: issue reads ahead, compact survivors behind
			if (state_q == S_TICK) begin
				if (rd_en) begin
					issue_q <= issue_q + 1'b1;
					rp_q    <= ptr_inc(rp_q);
				end
				if (rd_vld_s1) begin
					proc_q <= proc_q + 1'b1;
					if (keep) begin
						kept_q <= kept_q + 1'b1;
						wp_q   <= ptr_inc(wp_q);
					end else begin
						exp_q <= exp_q + 1'b1;
					end
				end
				if (tick_done) begin
					count_q <= kept_q;
					tail_q  <= wp_q;
				end
			end

			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result assembly
	always_comb begin
		res_d = res_q;
		if (state_q == S_IDLE && accept) begin
			res_d              = '0;
			res_d.queue_length = 7'(count_q);
			case (req.operation)
				OP_ENQ: begin
					if (is_full) begin
						res_d.status = ST_FULL;
					end else begin
						res_d.queue_length = 7'(count_q + 1'b1);
					end
				end
				OP_DEQ: begin
					if (is_empty) begin
						res_d.status = ST_EMPTY;
					end
				end
				default: ;
			endcase
		end
		if (state_q == S_DEQ) begin
			res_d.removed_id           = rd_data.id;
			res_d.removed_service_time = rd_data.svc;
			res_d.queue_length         = 7'(count_q - 1'b1);
		end
		if (tick_done) begin
			res_d.expired_count = 7'(exp_q);
			res_d.queue_length  = 7'(kept_q);
		end
	end

	// result and response registers
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (fin_go) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/fqt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqt_checker
// Port-level checks on the timeout queue, bound to the top level.
// ----------------------------------------------------------------------------
module fqt_checker #(
	parameter int QUEUE_DEPTH = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input fqt_pkg::req_word_t req,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input fqt_pkg::rsp_word_t rsp
);
	import fqt_pkg::*;

	// a held response word stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// one request in flight: intake closes right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while busy");

	// a refused enqueue reports a full queue
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.queue_length == 7'(QUEUE_DEPTH))
		else $error("full status with wrong length");

	// an empty dequeue reports nothing removed and no entries
	a_empty_deq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |->
		rsp.queue_length == '0 && rsp.removed_id == '0 && rsp.expired_count == '0)
		else $error("empty status with nonzero fields");

	// a timeout only shows on a successful operation
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.expired_count != '0 |->
		rsp.status == ST_OK && rsp.removed_id == '0)
		else $error("expired count on non-tick result");

endmodule

bind fifo_queue_with_entry_timeout fqt_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fqt_checker (.*);

// ===== dv/fifo_queue_with_entry_timeout_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_entry_timeout_tb
// Self-checking bench for the timeout queue. Each accepted request word runs
// through a local model of the entry store. The model's response word is
// queued and compared field by field with the next word taken from rsp.
// Directed cases cover the empty queue, field extremes and expiry in the
// middle of the queue. Random phases fill the queue to full and mix
// enqueues, dequeues and ticks with random content, under three idle
// profiles.
// ----------------------------------------------------------------------------
module fifo_queue_with_entry_timeout_tb;
	import fqt_pkg::*;

	localparam int QUEUE_DEPTH = 64;
	localparam logic [1:0] OP_NONE = 2'd3;	// unused code, no effect
	localparam int MAX_REPORTS = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	req_word_t req = '0;
	logic      rsp_stall = 1'b0;
	logic      req_stall;
	logic      rsp_valid;
	rsp_word_t rsp;

	always #5 clk = ~clk;

	fifo_queue_with_entry_timeout #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// model of the entry store, front at index 0
	logic [15:0] q_id     [QUEUE_DEPTH];
	logic [15:0] q_limit  [QUEUE_DEPTH];
	logic [15:0] q_svc    [QUEUE_DEPTH];
	logic [15:0] q_waited [QUEUE_DEPTH];
	int          q_count = 0;

	rsp_word_t pending_rsp[$];
	rsp_word_t rsp_exp;
	int        mismatches = 0;
	int        send_idle_pct = 0;
	int        rcv_idle_pct = 0;

	// apply one operation to the model, return the response word it gives
	function automatic rsp_word_t queue_model_step(req_word_t w);
		rsp_word_t r;
		int        i;
		int        kept;
		r = '0;
		case (w.operation)
			OP_ENQ: begin
				if (q_count >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					q_id[q_count]     = w.customer_id;
					q_limit[q_count]  = w.wait_limit;
					q_svc[q_count]    = w.service_time;
					q_waited[q_count] = 16'd0;
					q_count++;
				end
			end
			OP_DEQ: begin
				if (q_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.removed_id           = q_id[0];
					r.removed_service_time = q_svc[0];
					for (i = 1; i < q_count; i++) begin
						q_id[i-1]     = q_id[i];
						q_limit[i-1]  = q_limit[i];
						q_svc[i-1]    = q_svc[i];
						q_waited[i-1] = q_waited[i];
					end
					q_count--;
				end
			end
			OP_TICK: begin
				// expire timed-out entries, age and compact the rest
				kept = 0;
				for (i = 0; i < q_count; i++) begin
					if (q_waited[i] >= q_limit[i]) begin
						r.expired_count = r.expired_count + 7'd1;
					end else begin
						if (q_waited[i] != WAIT_MAX)
							q_waited[i] = q_waited[i] + 16'd1;
						q_id[kept]     = q_id[i];
						q_limit[kept]  = q_limit[i];
						q_svc[kept]    = q_svc[i];
						q_waited[kept] = q_waited[i];
						kept++;
					end
				end
				q_count = kept;
			end
			default: begin
			end
		endcase
		r.queue_length = q_count[6:0];
		return r;
	endfunction

	function automatic req_word_t make_word(logic [1:0] op, logic [15:0] id,
			logic [15:0] limit, logic [15:0] svc);
		req_word_t w;
		w.operation    = op;
		w.customer_id  = id;
		w.wait_limit   = limit;
		w.service_time = svc;
		return w;
	endfunction

	// mostly short limits so ticks expire entries, some over the full range
	function automatic logic [15:0] rand_limit();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 16'($urandom_range(12));
		else if (r < 90)
			return 16'($urandom_range(300));
		return 16'($urandom_range(16'hFFFF));
	endfunction

	function automatic req_word_t rand_word(logic [1:0] op);
		return make_word(op, 16'($urandom_range(16'hFFFF)), rand_limit(),
			16'($urandom_range(16'hFFFF)));
	endfunction

	// called at a falling edge; returns at the falling edge after accept
	task automatic send_word(req_word_t w);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			if ($urandom_range(9) == 0)
				gap = $urandom_range(80, 8);
			else
				gap = $urandom_range(4, 1);
			repeat (gap) @(negedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		pending_rsp.push_back(queue_model_step(w));
		@(negedge clk);
	endtask

	// hold the sender off until every response has come back
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_rsp.size() != 0);
	endtask

	// receiver stall
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	task automatic note_mismatch(string what, logic [63:0] e, logic [63:0] a);
		if (mismatches < MAX_REPORTS)
			$display("%0t mismatch %s: expected %0h, got %0h", $time, what, e, a);
		mismatches++;
	endtask

	// response check against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				note_mismatch("unexpected word", 64'd0, 64'(rsp));
			end else begin
				rsp_exp = pending_rsp.pop_front();
				if (rsp.status !== rsp_exp.status)
					note_mismatch("status", 64'(rsp_exp.status), 64'(rsp.status));
				if (rsp.removed_id !== rsp_exp.removed_id)
					note_mismatch("removed_id", 64'(rsp_exp.removed_id),
						64'(rsp.removed_id));
				if (rsp.removed_service_time !== rsp_exp.removed_service_time)
					note_mismatch("removed_service_time",
						64'(rsp_exp.removed_service_time),
						64'(rsp.removed_service_time));
				if (rsp.expired_count !== rsp_exp.expired_count)
					note_mismatch("expired_count", 64'(rsp_exp.expired_count),
						64'(rsp.expired_count));
				if (rsp.queue_length !== rsp_exp.queue_length)
					note_mismatch("queue_length", 64'(rsp_exp.queue_length),
						64'(rsp.queue_length));
			end
		end
	end

	// dequeue, tick and unused code on an empty queue
	task automatic test_empty_queue();
		send_word(make_word(OP_DEQ, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_word(make_word(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_word(make_word(OP_NONE, 16'h0000, 16'h0000, 16'h0000));
		send_word(make_word(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
	endtask

	// field extremes through enqueue and dequeue, then dequeue past empty
	task automatic test_enq_deq_extremes();
		send_word(make_word(OP_ENQ, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_word(make_word(OP_ENQ, 16'h0000, 16'h0000, 16'h0000));
		send_word(make_word(OP_ENQ, 16'hA5A5, 16'h5A5A, 16'h0F0F));
		repeat (4) send_word(make_word(OP_DEQ, 16'h0000, 16'h0000, 16'h0000));
	endtask

	// expiry at the middle and rear, survivors compacted in order
	task automatic test_tick_expiry();
		send_word(make_word(OP_ENQ, 16'h0011, 16'hFFFF, 16'h0101));
		send_word(make_word(OP_ENQ, 16'h0022, 16'h0000, 16'h0202));
		send_word(make_word(OP_ENQ, 16'h0033, 16'h0001, 16'h0303));
		send_word(make_word(OP_ENQ, 16'h0044, 16'h0000, 16'h0404));
		send_word(make_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
		send_word(make_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
		send_word(make_word(OP_NONE, 16'h1234, 16'h5678, 16'h9ABC));
		send_word(make_word(OP_DEQ, 16'h0000, 16'h0000, 16'h0000));
		send_word(make_word(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
	endtask

	// fill to full, refused enqueues, then partial drain by ticks
	task automatic test_full_queue();
		while (q_count < QUEUE_DEPTH)
			send_word(rand_word(OP_ENQ));
		repeat (2) send_word(rand_word(OP_ENQ));
		send_word(rand_word(OP_TICK));
		send_word(rand_word(OP_DEQ));
		send_word(rand_word(OP_ENQ));
		send_word(rand_word(OP_ENQ));
		repeat (4) send_word(rand_word(OP_TICK));
	endtask

	// episodes biased toward growing, shrinking or aging the queue
	task automatic test_random_mix(int n);
		int done;
		int len;
		int bias;
		int r;
		logic [1:0] op;
		done = 0;
		while (done < n) begin
			len  = $urandom_range(50, 10);
			bias = $urandom_range(2);
			repeat (len) begin
				r = $urandom_range(99);
				case (bias)
					0: op = (r < 65) ? OP_ENQ : (r < 75) ? OP_DEQ : (r < 95) ? OP_TICK : OP_NONE;
					1: op = (r < 20) ? OP_ENQ : (r < 65) ? OP_DEQ : (r < 95) ? OP_TICK : OP_NONE;
					default: op = (r < 35) ? OP_ENQ : (r < 50) ? OP_DEQ : (r < 95) ? OP_TICK :
						OP_NONE;
				endcase
				send_word(rand_word(op));
				done++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 34;
					rcv_idle_pct  = 66;
				end
				1: begin
					send_idle_pct = 66;
					rcv_idle_pct  = 34;
				end
				default: begin
					send_idle_pct = 0;
					rcv_idle_pct  = 0;
				end
			endcase
			if (phase == 0) begin
				test_empty_queue();
				test_enq_deq_extremes();
				test_tick_expiry();
			end
			test_full_queue();
			test_random_mix(140);
			wait_for_drain();
			test_random_mix(140);
			wait_for_drain();
		end
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
